@@ sv/sqmpc_pkg.sv @@
// ----------------------------------------------------------------------------
// sqmpc_pkg
// Shared types and constants for the square matrix property checker.
// ----------------------------------------------------------------------------
package sqmpc_pkg;

    localparam int CFG_W      = 5;   // matrix_order register
    localparam int IN_W       = 32;  // element_value
    localparam int LINE_W     = 4;   // line_index
    localparam int OUT_DATA_W = 16;  // result tdata, padded to whole bytes

    localparam logic [CFG_W-1:0] ORDER_RESET = 5'd4;

    // result tdata bit positions
    localparam int BIT_ROW_ZERO  = 4;
    localparam int BIT_COL_ZERO  = 5;
    localparam int BIT_SYMMETRIC = 6;
    localparam int BIT_MAIN_ZERO = 7;
    localparam int BIT_ANTI_ZERO = 8;

    // position decode of one element, travels with the element
    typedef struct packed {
        logic upper;     // above the main diagonal: store it
        logic lower;     // below the main diagonal: check against mirror
        logic diag;
        logic anti;
        logic row_end;
        logic mat_end;
    } sqmpc_ctrl_t;

    // whole-matrix flags
    typedef struct packed {
        logic symmetric;
        logic main_zero;
        logic anti_zero;
    } sqmpc_glob_t;

endpackage

@@ sv/sqmpc_input_stage.sv @@
// ----------------------------------------------------------------------------
// sqmpc_input_stage
// Position counters, upper-triangle store and the element input register.
// ----------------------------------------------------------------------------
module sqmpc_input_stage #(
    parameter int MAX_ORDER = 16,
    parameter int DATA_W    = 32,
    parameter int POS_W     = 4,
    parameter int NW        = 5,
    parameter int ADDR_W    = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [sqmpc_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [sqmpc_pkg::IN_W-1:0] s_axis_tdata,
    input  logic                       a_fire,
    output logic                       a_valid,
    output logic [DATA_W-1:0]          a_value,
    output logic [DATA_W-1:0]          a_mirror,
    output sqmpc_pkg::sqmpc_ctrl_t     a_ctrl,
    output logic [POS_W-1:0]           a_row,
    output logic [POS_W-1:0]           a_col,
    output logic [NW-1:0]              n_eff
);

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;

    logic [sqmpc_pkg::CFG_W-1:0] order_reg;
    logic [POS_W-1:0]            row_reg, row_next;
    logic [POS_W-1:0]            col_reg, col_next;
    logic                        a_valid_reg, a_valid_next;
    logic [DATA_W-1:0]           value_reg;
    logic [DATA_W-1:0]           mirror_reg;
    sqmpc_pkg::sqmpc_ctrl_t      ctrl_reg, ctrl_next;
    logic [POS_W-1:0]            a_row_reg;
    logic [POS_W-1:0]            a_col_reg;
    logic [DATA_W-1:0]           mem [DEPTH];

    logic                        accept;
    logic [NW-1:0]               order_ext;
    logic [NW-1:0]               n_last;
    logic [NW-1:0]               row_ext;
    logic [NW-1:0]               col_ext;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic [DATA_W-1:0]           in_value;

    assign order_ext = NW'(order_reg);
    assign n_eff     = (order_ext == '0) ? NW'(1) :
                       (order_ext > NW'(MAX_ORDER)) ? NW'(MAX_ORDER) : order_ext;
    assign n_last    = n_eff - NW'(1);
    assign row_ext   = NW'(row_reg);
    assign col_ext   = NW'(col_reg);
    assign in_value  = s_axis_tdata[DATA_W-1:0];

    assign s_axis_tready = !a_valid_reg || a_fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign wr_addr = ADDR_W'(row_reg) * ADDR_W'(MAX_ORDER) + ADDR_W'(col_reg);
    assign rd_addr = ADDR_W'(col_reg) * ADDR_W'(MAX_ORDER) + ADDR_W'(row_reg);

    always_comb begin
        ctrl_next.upper   = col_reg > row_reg;
        ctrl_next.lower   = col_reg < row_reg;
        ctrl_next.diag    = col_reg == row_reg;
        ctrl_next.anti    = col_ext == (n_last - row_ext);
        ctrl_next.row_end = col_ext == n_last;
        ctrl_next.mat_end = (col_ext == n_last) && (row_ext == n_last);

        row_next = row_reg;
        col_next = col_reg;
        if (ctrl_next.row_end) begin
            col_next = '0;
            row_next = ctrl_next.mat_end ? '0 : row_reg + POS_W'(1);
        end else begin
            col_next = col_reg + POS_W'(1);
        end

        a_valid_next = accept || (a_valid_reg && !a_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg   <= sqmpc_pkg::ORDER_RESET;
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            if (cfg_wr_en) begin
                order_reg <= cfg_wr_data;
                row_reg   <= '0;
                col_reg   <= '0;
            end else if (accept) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // the mirror of a below-diagonal element is always written at least one transaction before it is read
    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg  <= in_value;
            mirror_reg <= mem[rd_addr];
            ctrl_reg   <= ctrl_next;
            a_row_reg  <= row_reg;
            a_col_reg  <= col_reg;
            if (ctrl_next.upper) begin
                mem[wr_addr] <= in_value;
            end
        end
    end

    assign a_valid  = a_valid_reg;
    assign a_value  = value_reg;
    assign a_mirror = mirror_reg;
    assign a_ctrl   = ctrl_reg;
    assign a_row    = a_row_reg;
    assign a_col    = a_col_reg;

endmodule

@@ sv/sqmpc_flag_unit.sv @@
// ----------------------------------------------------------------------------
// sqmpc_flag_unit
// Symmetry and zero-line flags, updated once per element.
// ----------------------------------------------------------------------------
module sqmpc_flag_unit #(
    parameter int MAX_ORDER = 16,
    parameter int DATA_W    = 32,
    parameter int POS_W     = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   a_fire,
    input  logic [DATA_W-1:0]      a_value,
    input  logic [DATA_W-1:0]      a_mirror,
    input  sqmpc_pkg::sqmpc_ctrl_t a_ctrl,
    input  logic [POS_W-1:0]       a_row,
    input  logic [POS_W-1:0]       a_col,
    output logic [MAX_ORDER-1:0]   fin_row_zero,
    output logic [MAX_ORDER-1:0]   fin_col_zero,
    output sqmpc_pkg::sqmpc_glob_t fin_glob
);

    logic                   cur_row_zero_reg, cur_row_zero_next;
    logic [MAX_ORDER-1:0]   row_zero_reg, row_zero_next;
    logic [MAX_ORDER-1:0]   col_zero_reg, col_zero_next;
    sqmpc_pkg::sqmpc_glob_t glob_reg, glob_next;
    logic                   nonzero;
    logic                   row_nonzero;

    always_comb begin
        nonzero     = a_value != '0;
        row_nonzero = !cur_row_zero_reg || nonzero;

        glob_next = glob_reg;
        if (a_ctrl.lower && (a_mirror != a_value)) begin
            glob_next.symmetric = 1'b0;
        end
        if (nonzero && a_ctrl.diag) begin
            glob_next.main_zero = 1'b0;
        end
        if (nonzero && a_ctrl.anti) begin
            glob_next.anti_zero = 1'b0;
        end

        for (int i = 0; i < MAX_ORDER; i++) begin
            col_zero_next[i] = col_zero_reg[i] && !(nonzero && (a_col == POS_W'(i)));
            row_zero_next[i] = row_zero_reg[i] &&
                               !(a_ctrl.row_end && row_nonzero && (a_row == POS_W'(i)));
        end

        cur_row_zero_next = a_ctrl.row_end ? 1'b1 : !row_nonzero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (a_fire && a_ctrl.mat_end)) begin
            cur_row_zero_reg <= 1'b1;
            row_zero_reg     <= '1;
            col_zero_reg     <= '1;
            glob_reg         <= '1;
        end else if (a_fire) begin
            cur_row_zero_reg <= cur_row_zero_next;
            row_zero_reg     <= row_zero_next;
            col_zero_reg     <= col_zero_next;
            glob_reg         <= glob_next;
        end
    end

    assign fin_row_zero = row_zero_next;
    assign fin_col_zero = col_zero_next;
    assign fin_glob     = glob_next;

endmodule

@@ sv/sqmpc_result_seq.sv @@
// ----------------------------------------------------------------------------
// sqmpc_result_seq
// Holds the final flags of a matrix and sends one result per line index.
// ----------------------------------------------------------------------------
module sqmpc_result_seq #(
    parameter int MAX_ORDER = 16,
    parameter int POS_W     = 4,
    parameter int NW        = 5
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  logic [MAX_ORDER-1:0]             fin_row_zero,
    input  logic [MAX_ORDER-1:0]             fin_col_zero,
    input  sqmpc_pkg::sqmpc_glob_t           fin_glob,
    input  logic [NW-1:0]                    n_eff,
    output logic                             free,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sqmpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);

    logic                   busy_reg;
    logic [POS_W-1:0]       idx_reg;
    logic [MAX_ORDER-1:0]   row_snap_reg;
    logic [MAX_ORDER-1:0]   col_snap_reg;
    sqmpc_pkg::sqmpc_glob_t glob_snap_reg;
    logic                   is_last;
    logic                   sent;

    assign is_last = NW'(idx_reg) == (n_eff - NW'(1));
    assign sent    = busy_reg && m_axis_tready;
    assign free    = !busy_reg || (m_axis_tready && is_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (sent) begin
            if (is_last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            row_snap_reg  <= fin_row_zero;
            col_snap_reg  <= fin_col_zero;
            glob_snap_reg <= fin_glob;
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[sqmpc_pkg::LINE_W-1:0]        = sqmpc_pkg::LINE_W'(idx_reg);
        m_axis_tdata[sqmpc_pkg::BIT_ROW_ZERO]  = row_snap_reg[idx_reg];
        m_axis_tdata[sqmpc_pkg::BIT_COL_ZERO]  = col_snap_reg[idx_reg];
        m_axis_tdata[sqmpc_pkg::BIT_SYMMETRIC] = glob_snap_reg.symmetric;
        m_axis_tdata[sqmpc_pkg::BIT_MAIN_ZERO] = glob_snap_reg.main_zero;
        m_axis_tdata[sqmpc_pkg::BIT_ANTI_ZERO] = glob_snap_reg.anti_zero;
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tlast  = is_last;

endmodule

@@ sv/square_matrix_property_check.sv @@
// ----------------------------------------------------------------------------
// square_matrix_property_check
// Symmetry and zero row/column/diagonal check of an n-by-n matrix streamed
// in row-major order; n results after the last element.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  s_axis   | in        | one matrix element, row-major
//  m_axis   | out       | one result per line index, tlast on index n-1
//  cfg_wr   | in        | matrix_order write, restarts the run
//
//  One element per cycle unless stalled. Elements pass one input register
//  and update the flags on leaving it; the last element starts a burst of
//  n results, one per cycle while m_axis_tready is high, from a snapshot
//  register. s_axis_tready drops only while a finished matrix waits for the
//  previous result burst to drain. Reset is synchronous; the element store
//  needs no clearing, as each mirror entry is written before it is read.
// ----------------------------------------------------------------------------
module square_matrix_property_check #(
    parameter int MAX_ORDER     = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [sqmpc_pkg::CFG_W-1:0]      cfg_wr_data,   // matrix_order
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sqmpc_pkg::IN_W-1:0]       s_axis_tdata,  // [31:0] element_value
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [3:0] line_index, [4] row_is_zero, [5] column_is_zero, [6] is_symmetric,
    // [7] main_diagonal_zero, [8] anti_diagonal_zero, [15:9] zero
    output logic [sqmpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast   // last_of_run
);

    localparam int DATA_W = (ELEMENT_WIDTH < sqmpc_pkg::IN_W) ? ELEMENT_WIDTH
                                                               : sqmpc_pkg::IN_W;
    localparam int POS_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W  = $clog2(MAX_ORDER + 1);
    localparam int NW     = (CNT_W > sqmpc_pkg::CFG_W) ? CNT_W : sqmpc_pkg::CFG_W;
    localparam int ADDR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;

    logic                   a_valid;
    logic                   a_fire;
    logic [DATA_W-1:0]      a_value;
    logic [DATA_W-1:0]      a_mirror;
    sqmpc_pkg::sqmpc_ctrl_t a_ctrl;
    logic [POS_W-1:0]       a_row;
    logic [POS_W-1:0]       a_col;
    logic [NW-1:0]          n_eff;
    logic [MAX_ORDER-1:0]   fin_row_zero;
    logic [MAX_ORDER-1:0]   fin_col_zero;
    sqmpc_pkg::sqmpc_glob_t fin_glob;
    logic                   seq_free;

    // a finished matrix may only leave the input register once the sequencer can load
    assign a_fire = a_valid && (!a_ctrl.mat_end || seq_free);

    sqmpc_input_stage #(
        .MAX_ORDER (MAX_ORDER),
        .DATA_W    (DATA_W),
        .POS_W     (POS_W),
        .NW        (NW),
        .ADDR_W    (ADDR_W)
    ) u_input (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .a_fire        (a_fire),
        .a_valid       (a_valid),
        .a_value       (a_value),
        .a_mirror      (a_mirror),
        .a_ctrl        (a_ctrl),
        .a_row         (a_row),
        .a_col         (a_col),
        .n_eff         (n_eff)
    );

    sqmpc_flag_unit #(
        .MAX_ORDER (MAX_ORDER),
        .DATA_W    (DATA_W),
        .POS_W     (POS_W)
    ) u_flags (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .a_fire       (a_fire),
        .a_value      (a_value),
        .a_mirror     (a_mirror),
        .a_ctrl       (a_ctrl),
        .a_row        (a_row),
        .a_col        (a_col),
        .fin_row_zero (fin_row_zero),
        .fin_col_zero (fin_col_zero),
        .fin_glob     (fin_glob)
    );

    sqmpc_result_seq #(
        .MAX_ORDER (MAX_ORDER),
        .POS_W     (POS_W),
        .NW        (NW)
    ) u_results (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (a_fire && a_ctrl.mat_end),
        .fin_row_zero  (fin_row_zero),
        .fin_col_zero  (fin_col_zero),
        .fin_glob      (fin_glob),
        .n_eff         (n_eff),
        .free          (seq_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
